[src/assert_macros.svh]
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MRWT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define MRWT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/mrwt_pkg.sv]
`timescale 1ns / 1ps
package mrwt_pkg;

	// verdict codes
	localparam logic [1:0] VERDICT_COMPOSITE = 2'd0;
	localparam logic [1:0] VERDICT_PRIME     = 2'd1;
	localparam logic [1:0] VERDICT_INVALID   = 2'd2;

	// small candidates settled without arithmetic
	localparam int unsigned SMALL_COMPOSITE = 4;
	localparam int unsigned SMALL_PRIME_MAX = 5;

	// operand selection for the modular multiplier
	localparam logic [1:0] MSEL_RED = 2'd0; // 1 * witness -> base (reduction)
	localparam logic [1:0] MSEL_XB  = 2'd1; // x * base -> x
	localparam logic [1:0] MSEL_BB  = 2'd2; // base * base -> base
	localparam logic [1:0] MSEL_XX  = 2'd3; // x * x -> x

	typedef struct packed {
		logic       load;
		logic       strip;
		logic       mul_start;
		logic [1:0] mul_sel;
		logic       mul_step;
		logic       e_shift;
		logic       s_dec;
	} cmd_t;

	typedef struct packed {
		logic n_lt2;
		logic n_eq4;
		logic n_le5;
		logic n_even;
		logic d_lsb;
		logic e_zero;
		logic e_lsb;
		logic mul_last;
		logic x_one;
		logic x_nm1;
		logic s_le1;
	} stat_t;

endpackage

[src/mrwt_datapath.sv]
`timescale 1ns / 1ps
module mrwt_datapath import mrwt_pkg::*; #(
	parameter int W = 64
) (
	input  logic         clk,
	input  cmd_t         cmd,
	input  logic [W-1:0] cand,
	input  logic [W-1:0] wit,
	output stat_t        stat
);

	localparam int SW = $clog2(W);

	logic [W-1:0]  n_q, nm1_q, w_q, d_q, x_q, base_q;
	logic [SW-1:0] s_q;
	logic [W-1:0]  ma_q, mb_q, mr_q;
	logic [SW-1:0] mcnt_q;
	logic          mdst_x_q;

	logic [W:0]    dbl, sum;
	logic [W-1:0]  r1, r2, op_a, op_b;

	// one shift-add step: r = 2r mod n, then r = r + a mod n when the multiplier bit is set
	always_comb begin
		dbl = {mr_q, 1'b0};
		r1  = (dbl >= {1'b0, n_q}) ? W'(dbl - {1'b0, n_q}) : dbl[W-1:0];
		sum = {1'b0, r1} + (mb_q[W-1] ? {1'b0, ma_q} : {(W+1){1'b0}});
		r2  = (sum >= {1'b0, n_q}) ? W'(sum - {1'b0, n_q}) : sum[W-1:0];
	end

	// operand select at multiply start
	always_comb begin
		unique case (cmd.mul_sel)
			MSEL_RED: begin
				op_a = W'(1);
				op_b = w_q;
			end
			MSEL_XB: begin
				op_a = x_q;
				op_b = base_q;
			end
			MSEL_BB: begin
				op_a = base_q;
				op_b = base_q;
			end
			default: begin
				op_a = x_q;
				op_b = x_q;
			end
		endcase
	end

	// operand, exponent and multiplier registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q   <= cand;
			nm1_q <= cand - W'(1);
			d_q   <= cand - W'(1);
			w_q   <= wit;
			x_q   <= W'(1);
			s_q   <= '0;
		end
		if (cmd.strip) begin
			d_q <= d_q >> 1;
			s_q <= s_q + SW'(1);
		end
		if (cmd.e_shift)
			d_q <= d_q >> 1;
		if (cmd.s_dec)
			s_q <= s_q - SW'(1);
		if (cmd.mul_start) begin
			ma_q     <= op_a;
			mb_q     <= op_b;
			mr_q     <= '0;
			mcnt_q   <= SW'(W - 1);
			mdst_x_q <= (cmd.mul_sel == MSEL_XB) || (cmd.mul_sel == MSEL_XX);
		end
		if (cmd.mul_step) begin
			mr_q   <= r2;
			mb_q   <= mb_q << 1;
			mcnt_q <= mcnt_q - SW'(1);
			if (mcnt_q == '0) begin
				if (mdst_x_q)
					x_q <= r2;
				else
					base_q <= r2;
			end
		end
	end

	// status to the controller
	always_comb begin
		stat.n_lt2    = n_q < W'(2);
		stat.n_eq4    = n_q == W'(SMALL_COMPOSITE);
		stat.n_le5    = n_q <= W'(SMALL_PRIME_MAX);
		stat.n_even   = ~n_q[0];
		stat.d_lsb    = d_q[0];
		stat.e_zero   = d_q == '0;
		stat.e_lsb    = d_q[0];
		stat.mul_last = mcnt_q == '0;
		stat.x_one    = x_q == W'(1);
		stat.x_nm1    = x_q == nm1_q;
		stat.s_le1    = s_q <= SW'(1);
	end

endmodule

[src/mrwt_ctrl.sv]
`timescale 1ns / 1ps
module mrwt_ctrl import mrwt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] verdict,
	input  stat_t      stat,
	output cmd_t       cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CHECK = 4'd1;
	localparam logic [3:0] ST_STRIP = 4'd2;
	localparam logic [3:0] ST_RED   = 4'd3;
	localparam logic [3:0] ST_POW   = 4'd4;
	localparam logic [3:0] ST_MULX  = 4'd5;
	localparam logic [3:0] ST_BSQ   = 4'd6;
	localparam logic [3:0] ST_MULB  = 4'd7;
	localparam logic [3:0] ST_TEST  = 4'd8;
	localparam logic [3:0] ST_SQR   = 4'd9;
	localparam logic [3:0] ST_SQCHK = 4'd10;
	localparam logic [3:0] ST_FIN   = 4'd11;

	logic [3:0] state_q, state_d;
	logic [1:0] pend_q, pend_d;
	logic       out_valid_q;
	logic [1:0] verdict_q;
	logic       out_free;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign verdict   = verdict_q;
	assign out_free  = !out_valid_q || out_ready;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		pend_d  = pend_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = ST_FIN;
				if (stat.n_lt2)
					pend_d = VERDICT_INVALID;
				else if (stat.n_eq4)
					pend_d = VERDICT_COMPOSITE;
				else if (stat.n_le5)
					pend_d = VERDICT_PRIME;
				else if (stat.n_even)
					pend_d = VERDICT_COMPOSITE;
				else
					state_d = ST_STRIP;
			end
			ST_STRIP: begin
				if (!stat.d_lsb) begin
					cmd.strip = 1'b1;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MSEL_RED;
					state_d       = ST_RED;
				end
			end
			ST_RED: begin
				cmd.mul_step = 1'b1;
				if (stat.mul_last)
					state_d = ST_POW;
			end
			// square-and-multiply, exponent taken from its low bit
			ST_POW: begin
				if (stat.e_zero) begin
					state_d = ST_TEST;
				end else if (stat.e_lsb) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MSEL_XB;
					state_d       = ST_MULX;
				end else begin
					state_d = ST_BSQ;
				end
			end
			ST_MULX: begin
				cmd.mul_step = 1'b1;
				if (stat.mul_last)
					state_d = ST_BSQ;
			end
			ST_BSQ: begin
				cmd.mul_start = 1'b1;
				cmd.mul_sel   = MSEL_BB;
				cmd.e_shift   = 1'b1;
				state_d       = ST_MULB;
			end
			ST_MULB: begin
				cmd.mul_step = 1'b1;
				if (stat.mul_last)
					state_d = ST_POW;
			end
			ST_TEST: begin
				if (stat.x_one || stat.x_nm1) begin
					pend_d  = VERDICT_PRIME;
					state_d = ST_FIN;
				end else if (stat.s_le1) begin
					pend_d  = VERDICT_COMPOSITE;
					state_d = ST_FIN;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MSEL_XX;
					cmd.s_dec     = 1'b1;
					state_d       = ST_SQR;
				end
			end
			ST_SQR: begin
				cmd.mul_step = 1'b1;
				if (stat.mul_last)
					state_d = ST_SQCHK;
			end
			// repeated squaring, watching for n - 1 or 1
			ST_SQCHK: begin
				if (stat.x_nm1) begin
					pend_d  = VERDICT_PRIME;
					state_d = ST_FIN;
				end else if (stat.x_one || stat.s_le1) begin
					pend_d  = VERDICT_COMPOSITE;
					state_d = ST_FIN;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel   = MSEL_XX;
					cmd.s_dec     = 1'b1;
					state_d       = ST_SQR;
				end
			end
			ST_FIN: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_q      <= VERDICT_COMPOSITE;
			out_valid_q <= 1'b0;
			verdict_q   <= VERDICT_COMPOSITE;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
				verdict_q   <= pend_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[src/miller_rabin_witness_test_unit.sv]
`timescale 1ns / 1ps
// One Miller-Rabin round: candidate and witness in, one verdict out
// (0 composite, 1 probably prime, 2 candidate below two).
// Input channel in_valid/in_ready carries candidate and witness; output
// channel out_valid/out_ready carries verdict. Only the low OPERAND_WIDTH
// bits of each input are used.
// One transaction is in work at a time; in_ready is high only when idle.
// Small and even candidates are settled in the check state without any
// multiplication. Otherwise factors of two are stripped from the candidate
// minus one, then every modular product runs on one shift-add multiplier
// at one bit per cycle: one reduction, up to two products per exponent
// bit, then up to s-1 squarings.
// The verdict sits in an output register; while the receiver stalls, the
// next transaction is accepted and computed, then waits for the slot.
// Reset clears the controller and the output valid; no clearing pass.
module miller_rabin_witness_test_unit import mrwt_pkg::*; #(
	parameter int OPERAND_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] candidate,
	input  logic [63:0] witness,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  verdict
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	mrwt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.verdict   (verdict),
		.stat      (stat),
		.cmd       (cmd)
	);

	// operand registers and modular multiplier
	mrwt_datapath #(.W(OPERAND_WIDTH)) u_dp (
		.clk  (clk),
		.cmd  (cmd),
		.cand (candidate[OPERAND_WIDTH-1:0]),
		.wit  (witness[OPERAND_WIDTH-1:0]),
		.stat (stat)
	);

endmodule

[src/mrwt_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mrwt_checker import mrwt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] verdict
);

	// busy right after a transaction is taken
	`MRWT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")

	// verdict code is always a legal one
	`MRWT_IMPLY(a_verdict_legal, out_valid, verdict <= VERDICT_INVALID, "illegal verdict")

	// stalled result holds
	`MRWT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(verdict), "result dropped")

endmodule

bind miller_rabin_witness_test_unit mrwt_checker u_mrwt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.verdict   (verdict)
);
